FILE: hw/rtl/spfl_pkg.sv
// ----------------------------------------------------------------------------
// spfl_pkg
// shared types and constants of the slot pool free list allocator
// ----------------------------------------------------------------------------
package spfl_pkg;

   localparam int SLOT_MAX           = 256;
   localparam int POOL_DEPTH_DEFAULT = 256;
   localparam int IDX_W              = 8;
   localparam int CNT_W              = 9;
   localparam int TYPE_W             = 16;
   localparam int STATUS_W           = 2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(256);

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_ALIVE = 2'd2
   } status_type;

   // one slot entry of the pool memory
   typedef struct packed {
      logic              alive;
      logic [IDX_W-1:0]  link;
      logic [TYPE_W-1:0] stype;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

FILE: hw/rtl/spfl_ram.sv
// ----------------------------------------------------------------------------
// spfl_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module spfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/slot_pool_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_pool_free_list_allocator_top
// slot pool allocator with free list, never-used watermark and stub slot 0
// ----------------------------------------------------------------------------
// Each request word is handled in ST_IDLE and ST_EXEC: on acceptance the
// addressed slot entry (free-list head on allocate, the given slot on free)
// is read from the pool memory, and in ST_EXEC it is checked and written back,
// head, watermark and live count are updated and the response register is
// loaded. The request side stalls only in ST_EXEC, which is extended while a
// finished response is still held. Alive marks need no clearing after reset:
// only slots below the never-used watermark are ever looked at, and each of
// those was written when it was first handed out.
// ----------------------------------------------------------------------------
module slot_pool_free_list_allocator_top #(
   parameter int POOL_DEPTH = spfl_pkg::POOL_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [spfl_pkg::IDX_W-1:0]    req_slot_index,
   input  logic [spfl_pkg::TYPE_W-1:0]   req_entry_type,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [spfl_pkg::IDX_W-1:0]    rsp_granted_index,
   output logic [spfl_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          csr_wr_en,
   input  logic [spfl_pkg::CNT_W-1:0]    csr_wr_data
);

   import spfl_pkg::*;

   localparam int SLOT_LIMIT = (POOL_DEPTH < SLOT_MAX) ? POOL_DEPTH : SLOT_MAX;
   localparam int AW         = $clog2(SLOT_LIMIT);
   localparam logic [CNT_W-1:0] SLOT_LIMIT_C = CNT_W'(SLOT_LIMIT);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  free_head_ff, free_head_in;
   logic [CNT_W-1:0]  high_water_ff, high_water_in;
   logic [CNT_W-1:0]  live_count_ff, live_count_in;
   logic [CNT_W-1:0]  capacity_ff, capacity_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              func_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [TYPE_W-1:0] type_ff;

   logic              accept;
   logic              commit;
   logic [CNT_W-1:0]  cap_eff;
   logic              full;
   logic              bad_free;
   logic              from_water;
   logic              alloc_ok;
   logic              free_ok;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   slot_entry_type    ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   slot_entry_type    ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_raw;

   spfl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_LIMIT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = slot_entry_type'(ram_rd_raw);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign ram_rd_addr = (req_func == FUNC_FREE) ? req_slot_index[AW-1:0]
                                                : free_head_ff[AW-1:0];

   assign cap_eff    = (capacity_ff > SLOT_LIMIT_C) ? SLOT_LIMIT_C : capacity_ff;
   assign full       = (live_count_ff >= cap_eff);
   assign from_water = (free_head_ff == high_water_ff);
   assign bad_free   = (idx_ff == '0) || ({1'b0, idx_ff} >= high_water_ff)
                       || !ram_rd_data.alive;
   assign alloc_ok   = (func_ff == FUNC_ALLOC) && !full;
   assign free_ok    = (func_ff == FUNC_FREE) && !bad_free;

   // write back of the slot entry
   always_comb begin
      ram_wr_en   = commit && (alloc_ok || free_ok);
      ram_wr_addr = free_head_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      if (func_ff == FUNC_FREE) begin
         ram_wr_addr       = idx_ff[AW-1:0];
         ram_wr_data.alive = 1'b0;
         ram_wr_data.link  = free_head_ff[IDX_W-1:0];
      end else begin
         ram_wr_data.alive = 1'b1;
         ram_wr_data.stype = type_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      high_water_in = high_water_ff;
      live_count_in = live_count_ff;
      capacity_in   = csr_wr_en ? csr_wr_data : capacity_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_status_in = STAT_OK;
               if (func_ff == FUNC_ALLOC) begin
                  if (full) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_index_in  = free_head_ff[IDX_W-1:0];
                     live_count_in = live_count_ff + CNT_W'(1);
                     if (from_water) begin
                        high_water_in = high_water_ff + CNT_W'(1);
                        free_head_in  = free_head_ff + CNT_W'(1);
                     end else begin
                        free_head_in = {1'b0, ram_rd_data.link};
                     end
                  end
               end else begin
                  if (bad_free) begin
                     rsp_status_in = STAT_NOT_ALIVE;
                  end else begin
                     free_head_in  = {1'b0, idx_ff};
                     live_count_in = live_count_ff - CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= CNT_W'(1);
         high_water_ff <= CNT_W'(1);
         live_count_ff <= CNT_W'(1);
         capacity_ff   <= CAPACITY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         high_water_ff <= high_water_in;
         live_count_ff <= live_count_in;
         capacity_ff   <= capacity_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         idx_ff  <= req_slot_index;
         type_ff <= req_entry_type;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
